>>> src/dbl_pkg.sv
// ----------------------------------------------------------------------------
// dbl_pkg: shared types and constants for the debounced button led chaser
// Register indexes, the lamp table and the structs passed between modules.
// ----------------------------------------------------------------------------
package dbl_pkg;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TIME = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LED_WAIT_TIME = 2'd1;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned DEBOUNCE_W = 8;
    localparam int unsigned WAIT_W     = 16;
    localparam int unsigned LAMP_W     = 4;
    localparam int unsigned RING_W     = 2;

    // register values after reset
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_TIME_RST = 8'd50;
    localparam logic [WAIT_W-1:0]     LED_WAIT_TIME_RST = 16'd500;

    // saturation limit of a debounce counter
    localparam logic [DEBOUNCE_W-1:0] COUNT_MAX = 8'd255;

    // lamp one-hot codes in ring order: red, blue, green, orange
    localparam logic [LAMP_W-1:0] LED_RED = 4'b0001;
    localparam logic [LAMP_W-1:0] LED_BLU = 4'b0010;
    localparam logic [LAMP_W-1:0] LED_GRN = 4'b0100;
    localparam logic [LAMP_W-1:0] LED_ORN = 4'b1000;

    function automatic logic [LAMP_W-1:0] lamp_bits(input logic [RING_W-1:0] idx);
        logic [LAMP_W-1:0] bits;
        unique case (idx)
            2'd0:    bits = LED_RED;
            2'd1:    bits = LED_BLU;
            2'd2:    bits = LED_GRN;
            default: bits = LED_ORN;
        endcase
        return bits;
    endfunction

    // one-shot press events of the three buttons
    typedef struct packed {
        logic start;
        logic green;
        logic red;
    } fire_t;

    // one result beat
    typedef struct packed {
        logic [LAMP_W-1:0] lamps;
        logic              backward;
        logic              running;
    } result_t;

endpackage

>>> src/dbl_debounce.sv
// ----------------------------------------------------------------------------
// dbl_debounce: one button debouncer with press edge detection
// Saturating hold counter, pressed level and a handled flag that lets each
// press fire exactly once.
// ----------------------------------------------------------------------------
module dbl_debounce
    import dbl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  tick_en,
    input  logic                  level,
    input  logic [DEBOUNCE_W-1:0] debounce_time,
    output logic                  fire
);

    logic [DEBOUNCE_W-1:0] count_reg, count_next;
    logic                  pressed_reg, pressed_next;
    logic                  handled_reg, handled_next;

    // counter, pressed level and one-shot for this tick
    always_comb begin
        if (!level) begin
            count_next   = '0;
            pressed_next = 1'b0;
        end else begin
            count_next   = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;
            pressed_next = (count_next > debounce_time) ? 1'b1 : pressed_reg;
        end
        fire = pressed_next && !handled_reg;
        if (fire) begin
            handled_next = 1'b1;
        end else if (!pressed_next) begin
            handled_next = 1'b0;
        end else begin
            handled_next = handled_reg;
        end
    end

    // state update on each tick taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            pressed_reg <= 1'b0;
            handled_reg <= 1'b0;
        end else if (tick_en) begin
            count_reg   <= count_next;
            pressed_reg <= pressed_next;
            handled_reg <= handled_next;
        end
    end

endmodule

>>> src/dbl_chaser.sv
// ----------------------------------------------------------------------------
// dbl_chaser: start/stop control, dwell timer and lamp ring
// Applies the press events of one tick and produces that tick's result.
// ----------------------------------------------------------------------------
module dbl_chaser
    import dbl_pkg::*;
#(
    parameter int unsigned LAMP_COUNT = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              tick_en,
    input  fire_t             fires,
    input  logic [WAIT_W-1:0] led_wait_time,
    output result_t           result
);

    localparam logic [RING_W-1:0] LAST_IDX = RING_W'(LAMP_COUNT - 1);

    logic              dir_reg, dir_next;
    logic              pending_reg, pending_next;
    logic              running_reg, running_next;
    logic [RING_W-1:0] idx_reg, idx_next;
    logic [WAIT_W-1:0] timer_reg, timer_next;

    // press actions, timer countdown and ring step in tick order
    always_comb begin
        dir_next     = dir_reg;
        pending_next = pending_reg;
        running_next = running_reg;
        idx_next     = idx_reg;
        timer_next   = timer_reg;

        if (fires.start) begin
            pending_next = 1'b1;
            timer_next   = led_wait_time;
        end
        if (fires.green) begin
            if (!running_reg) begin
                pending_next = 1'b1;
                timer_next   = led_wait_time;
            end else begin
                pending_next = 1'b0;
                running_next = 1'b0;
            end
        end
        if (fires.red) begin
            dir_next = !dir_reg;
        end

        if (timer_next != '0) begin
            timer_next = timer_next - 1'b1;
        end

        if (!running_next) begin
            if (pending_next) begin
                pending_next = 1'b0;
                running_next = 1'b1;
                idx_next     = '0;
                timer_next   = led_wait_time;
            end
        end else if (timer_next == '0) begin
            if (!dir_next) begin
                idx_next = (idx_reg >= LAST_IDX) ? '0 : idx_reg + 1'b1;
            end else begin
                idx_next = (idx_reg == '0) ? LAST_IDX : idx_reg - 1'b1;
            end
            timer_next = led_wait_time;
        end

        result.lamps    = running_next ? lamp_bits(idx_next) : '0;
        result.backward = dir_next;
        result.running  = running_next;
    end

    // chaser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg     <= 1'b0;
            pending_reg <= 1'b0;
            running_reg <= 1'b0;
            idx_reg     <= '0;
            timer_reg   <= '0;
        end else if (tick_en) begin
            dir_reg     <= dir_next;
            pending_reg <= pending_next;
            running_reg <= running_next;
            idx_reg     <= idx_next;
            timer_reg   <= timer_next;
        end
    end

endmodule

>>> src/debounced_button_led_chaser_top.sv
// ----------------------------------------------------------------------------
// debounced_button_led_chaser_top: three-button debounced LED chaser
// Input register, per-button debouncers, chaser control and result register.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat per 1 ms tick carrying the raw start, green and red
//   button levels. m_ channel: one result beat per tick with the lamp
//   pattern, the rotation direction and the running flag.
//   cfg channel: index 0 writes the debounce time, index 1 the lamp wait
//   time; other indexes are dropped. cfg_ready is always high; write only
//   while no tick is in flight.
//   Path: a tick accepted is held in the input register, and its result
//   is loaded into the output register once that register is free;
//   m_valid then rises.
//   Throughput: one tick per cycle unless a stalled result holds it; the
//   whole per-tick update is a short path from the input register
//   through the debouncers and chaser logic into the output register.
//   Reset (aresetn low, synchronous) empties both registers, clears all
//   counters and flags and loads the register defaults 50 and 500.
//   When m_ready is low the result holds; the input register still takes
//   one more beat, after which s_ready drops until the result drains.
// ----------------------------------------------------------------------------
module debounced_button_led_chaser_top
    import dbl_pkg::*;
#(
    parameter int unsigned LAMP_COUNT = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_start_button_raw,
    input  logic                   s_green_button_raw,
    input  logic                   s_red_button_raw,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [LAMP_W-1:0]      m_led_lamps,
    output logic                   m_rotate_backward,
    output logic                   m_chaser_running,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [DEBOUNCE_W-1:0] debounce_time_reg;
    logic [WAIT_W-1:0]     led_wait_time_reg;

    logic    in_valid_reg;
    logic    start_raw_reg, green_raw_reg, red_raw_reg;
    logic    out_valid_reg;
    result_t out_reg;

    logic    out_free;
    logic    tick_en;
    fire_t   fires;
    result_t result;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_time_reg <= DEBOUNCE_TIME_RST;
            led_wait_time_reg <= LED_WAIT_TIME_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DEBOUNCE_TIME: debounce_time_reg <= cfg_data[DEBOUNCE_W-1:0];
                CFG_LED_WAIT_TIME: led_wait_time_reg <= cfg_data[WAIT_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline flow control
    assign out_free = !out_valid_reg || m_ready;
    assign tick_en  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || tick_en;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            start_raw_reg <= s_start_button_raw;
            green_raw_reg <= s_green_button_raw;
            red_raw_reg   <= s_red_button_raw;
        end
    end

    // debouncers
    dbl_debounce u_db_start (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tick_en       (tick_en),
        .level         (start_raw_reg),
        .debounce_time (debounce_time_reg),
        .fire          (fires.start)
    );

    dbl_debounce u_db_green (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tick_en       (tick_en),
        .level         (green_raw_reg),
        .debounce_time (debounce_time_reg),
        .fire          (fires.green)
    );

    dbl_debounce u_db_red (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tick_en       (tick_en),
        .level         (red_raw_reg),
        .debounce_time (debounce_time_reg),
        .fire          (fires.red)
    );

    // chaser control
    dbl_chaser #(
        .LAMP_COUNT (LAMP_COUNT)
    ) u_chaser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tick_en       (tick_en),
        .fires         (fires),
        .led_wait_time (led_wait_time_reg),
        .result        (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_en) begin
            out_reg <= result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_led_lamps       = out_reg.lamps;
    assign m_rotate_backward = out_reg.backward;
    assign m_chaser_running  = out_reg.running;

endmodule

>>> src/dbl_checker.sv
// ----------------------------------------------------------------------------
// dbl_checker: port-level checks for the debounced button led chaser
// Watches the result channel and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
module dbl_checker
    import dbl_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [LAMP_W-1:0] m_led_lamps,
    input logic              m_rotate_backward,
    input logic              m_chaser_running
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat shown right after reset");

    // idle chaser shows all lamps dark
    a_idle_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_chaser_running) |-> (m_led_lamps == '0))
        else $error("lamps lit while chaser idle");

    // running chaser lights exactly one lamp
    a_run_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_chaser_running) |-> $onehot(m_led_lamps))
        else $error("running chaser lamps not one-hot");

    // stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_led_lamps)
            && $stable(m_rotate_backward) && $stable(m_chaser_running)))
        else $error("stalled result beat changed");

endmodule

bind debounced_button_led_chaser_top dbl_checker u_dbl_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_led_lamps       (m_led_lamps),
    .m_rotate_backward (m_rotate_backward),
    .m_chaser_running  (m_chaser_running)
);
